// ===== rtl/core/crt_pkg.sv =====
// Package for the connection redirect table: command codes, the request and
// response beat types, the stored entry type and the sequencer states.
// No dependencies.
`default_nettype none

package crt_pkg;

   localparam logic [1:0] CMD_ADD          = 2'd0;
   localparam logic [1:0] CMD_LOOKUP       = 2'd1;
   localparam logic [1:0] CMD_REMOVE_LOCAL = 2'd2;
   localparam logic [1:0] CMD_REMOVE_ORIG  = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] local_port;
      logic [31:0] original_ip;
      logic [15:0] original_port;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] found_ip;
      logic [15:0] found_port;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] local_port;
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
   } entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/crt_table.sv =====
// Entry store of the connection redirect table: one write port and one read
// port with registered read data. Depends on crt_pkg.
`default_nettype none

module crt_table #(
   parameter int unsigned ENTRIES = 64,
   parameter int unsigned ADDR_W  = $clog2(ENTRIES)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire crt_pkg::entry_type wr_data,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output crt_pkg::entry_type      rd_data
);
   import crt_pkg::*;

   entry_type entry_mem_ff [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/crt_match.sv =====
// Shared compare unit: decides whether one stored entry qualifies for the
// command being worked on. Depends on crt_pkg.
`default_nettype none

module crt_match (
   input  wire crt_pkg::req_type   req,
   input  wire crt_pkg::entry_type entry,
   output logic                    match
);
   import crt_pkg::*;

   always_comb begin
      case (req.command)
         CMD_ADD: begin
            match = !entry.valid;
         end
         CMD_LOOKUP, CMD_REMOVE_LOCAL: begin
            match = entry.valid && (entry.local_port == req.local_port);
         end
         CMD_REMOVE_ORIG: begin
            match = entry.valid && (entry.dest_ip == req.original_ip)
                    && (entry.dest_port == req.original_port);
         end
         default: begin
            match = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/connection_redirect_table_core.sv =====
// Top level of the connection redirect table: sequencer, result registers
// and assertions. Depends on crt_pkg, crt_table and crt_match.
`default_nettype none

// Channel   Ports                                   Direction  Beat
// request   req_valid, req_ready, req_payload       in         one command
// response  rsp_valid, rsp_ready, rsp_payload       out        one result
//
// After reset the block sweeps the table once to clear every valid mark,
// one entry at a time; no request is taken during the sweep.
// A command scans the table from entry 0 upward, one entry per cycle through
// the single read port of the entry store and the shared compare unit. A
// command that acts on entry k ends its scan there; a miss or a full table
// scans every entry. No request is taken until the result has been loaded.
// The response sits in an output register, so a scan proceeds while an
// earlier result waits; a finished scan holds only until that register frees.

module connection_redirect_table_core #(
   parameter int unsigned TABLE_ENTRIES = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire crt_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output crt_pkg::rsp_type      rsp_payload
);
   import crt_pkg::*;

   localparam int unsigned ADDR_W = $clog2(TABLE_ENTRIES);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);

   // Sequencer state.
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;   // next entry to read, also the sweep counter
   logic              issue_ff, issue_in;       // reads still to be issued
   logic              data_ok_ff, data_ok_in;   // read data belongs to cmp_addr_ff
   logic [ADDR_W-1:0] cmp_addr_ff, cmp_addr_in;
   req_type           cur_req_ff, cur_req_in;
   rsp_type           res_ff, res_in;           // finished result waiting for the output register

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;
   logic              rsp_load;

   // Entry store and compare unit.
   logic              tbl_we;
   logic [ADDR_W-1:0] tbl_waddr;
   entry_type         tbl_wdata;
   entry_type         tbl_rdata;
   logic              entry_match;

   crt_table #(
      .ENTRIES (TABLE_ENTRIES),
      .ADDR_W  (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (rd_addr_ff),
      .rd_data (tbl_rdata)
   );

   crt_match u_match (
      .req   (cur_req_ff),
      .entry (tbl_rdata),
      .match (entry_match)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rd_addr_ff   <= '0;
         issue_ff     <= 1'b0;
         data_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_addr_ff   <= rd_addr_in;
         issue_ff     <= issue_in;
         data_ok_ff   <= data_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_addr_ff    <= cmp_addr_in;
      cur_req_ff     <= cur_req_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_comb begin
      state_in    = state_ff;
      rd_addr_in  = rd_addr_ff;
      issue_in    = issue_ff;
      data_ok_in  = 1'b0;
      cmp_addr_in = cmp_addr_ff;
      cur_req_in  = cur_req_ff;
      res_in      = res_ff;
      req_ready   = 1'b0;
      rsp_load    = 1'b0;
      tbl_we      = 1'b0;
      tbl_waddr   = cmp_addr_ff;
      tbl_wdata   = '0;

      case (state_ff)
         ST_CLEAR: begin
            // Write an invalid entry at each address in turn.
            tbl_we    = 1'b1;
            tbl_waddr = rd_addr_ff;
            if (rd_addr_ff == LAST_ADDR) begin
               rd_addr_in = '0;
               state_in   = ST_IDLE;
            end else begin
               rd_addr_in = rd_addr_ff + ADDR_W'(1);
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cur_req_in = req_payload;
               rd_addr_in = '0;
               issue_in   = 1'b1;
               state_in   = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Read side: one entry address per cycle.
            if (issue_ff) begin
               data_ok_in  = 1'b1;
               cmp_addr_in = rd_addr_ff;
               if (rd_addr_ff == LAST_ADDR) begin
                  issue_in = 1'b0;
               end else begin
                  rd_addr_in = rd_addr_ff + ADDR_W'(1);
               end
            end
            // Compare side: the entry read in the previous cycle.
            if (data_ok_ff) begin
               if (entry_match) begin
                  tbl_we    = 1'b1;
                  tbl_waddr = cmp_addr_ff;
                  if (cur_req_ff.command == CMD_ADD) begin
                     tbl_wdata.valid      = 1'b1;
                     tbl_wdata.local_port = cur_req_ff.local_port;
                     tbl_wdata.dest_ip    = cur_req_ff.original_ip;
                     tbl_wdata.dest_port  = cur_req_ff.original_port;
                  end else begin
                     tbl_wdata       = tbl_rdata;
                     tbl_wdata.valid = 1'b0;
                  end
                  res_in     = '0;
                  res_in.hit = 1'b1;
                  if (cur_req_ff.command == CMD_LOOKUP) begin
                     res_in.found_ip   = tbl_rdata.dest_ip;
                     res_in.found_port = tbl_rdata.dest_port;
                  end
                  issue_in   = 1'b0;
                  data_ok_in = 1'b0;
                  state_in   = ST_DONE;
               end else if (cmp_addr_ff == LAST_ADDR) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res_ff;
      end else begin
         rsp_valid_in   = rsp_valid_ff && !rsp_ready;
         rsp_payload_in = rsp_payload_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A command holds the block: no second request beat right after one.
   a_one_cmd_at_a_time : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a command is in progress");

   // The table is written only by the clearing sweep or at a qualifying entry.
   a_write_source : assert property (@(posedge clock) disable iff (reset)
      tbl_we |-> (state_ff == ST_CLEAR)
                 || (state_ff == ST_SCAN && data_ok_ff && entry_match))
      else $error("unexpected table write");

   // A result is only ready after a scan has ended.
   a_done_after_scan : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> $past(state_ff) == ST_SCAN || $past(state_ff) == ST_DONE)
      else $error("result state entered without a scan");

endmodule

`default_nettype wire
